FILE: rtl/core/sse_pkg.sv
// Shared types and codes for the sparse set engine.
package sse_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ERASED  = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  localparam int unsigned KeyFieldW   = 16;
  localparam int unsigned PosFieldW   = 10;
  localparam int unsigned TotalFieldW = 11;

  typedef struct packed {
    req_e                 req_type;
    logic [KeyFieldW-1:0] key;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [PosFieldW-1:0]   position;
    logic [TotalFieldW-1:0] entry_total;
  } rsp_t;

endpackage

FILE: rtl/core/sparse_set_engine.sv
// Top level of the sparse set engine: request sequencer around the sparse and dense memories.

// A request is taken when start_i is high and busy_o is low. Insert, find, clear and an
// erase of a missing key visit S_LOOK and S_CHECK; an erase that hits adds S_MOVE. The
// path is set by the sparse memory read, the dependent dense memory read at the slot it
// returns, and for an erase the further dense read of the last key before the write-back.
// Exactly one result per request appears on rsp_o for a single cycle with done_o high, and
// the receiver cannot hold it off. No clearing pass is needed after reset: a sparse entry
// is trusted only when it lies below the count and the dense key there matches.
module sparse_set_engine #(
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned DENSE_DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sse_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output sse_pkg::rsp_t rsp_o
);

  localparam int unsigned PosW   = $clog2(DENSE_DEPTH);
  localparam int unsigned CntW   = $clog2(DENSE_DEPTH + 1);
  localparam int unsigned SpDepth = 1 << KEY_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_MOVE  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                done_q, done_d;
  sse_pkg::rsp_t       rsp_q, rsp_d;
  sse_pkg::req_e       type_q;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_in;

  logic                sp_re, sp_we;
  logic [KEY_BITS-1:0] sp_raddr, sp_waddr;
  logic [PosW-1:0]     sp_rdata, sp_wdata;
  logic                dn_re, dn_we;
  logic [PosW-1:0]     dn_raddr, dn_waddr;
  logic [KEY_BITS-1:0] dn_rdata, dn_wdata;

  logic accept, hit, full;

  assign key_in = KEY_BITS'(req_i.key);
  assign accept = start_i && (state_q == S_IDLE);
  assign hit    = (CntW'(sp_rdata) < count_q) && (dn_rdata == key_q);
  assign full   = (count_q == CntW'(DENSE_DEPTH));

  sse_ram #(
    .Depth (SpDepth),
    .Width (PosW)
  ) u_sparse (
    .clk_i   (clk_i),
    .re_i    (sp_re),
    .raddr_i (sp_raddr),
    .rdata_o (sp_rdata),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata)
  );

  sse_ram #(
    .Depth (DENSE_DEPTH),
    .Width (KEY_BITS)
  ) u_dense (
    .clk_i   (clk_i),
    .re_i    (dn_re),
    .raddr_i (dn_raddr),
    .rdata_o (dn_rdata),
    .we_i    (dn_we),
    .waddr_i (dn_waddr),
    .wdata_i (dn_wdata)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    sp_re    = 1'b0;
    sp_raddr = key_in;
    sp_we    = 1'b0;
    sp_waddr = key_q;
    sp_wdata = PosW'(count_q);
    dn_re    = 1'b0;
    dn_raddr = sp_rdata;
    dn_we    = 1'b0;
    dn_waddr = PosW'(count_q);
    dn_wdata = key_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sp_re   = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        dn_re   = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d        = S_IDLE;
        done_d         = 1'b1;
        rsp_d.position = '0;
        case (type_q)
          sse_pkg::REQ_INSERT: begin
            if (hit) begin
              rsp_d.status   = sse_pkg::ST_PRESENT;
              rsp_d.position = sse_pkg::PosFieldW'(sp_rdata);
            end else if (full) begin
              rsp_d.status = sse_pkg::ST_FULL;
            end else begin
              sp_we          = 1'b1;
              dn_we          = 1'b1;
              count_d        = count_q + CntW'(1);
              rsp_d.status   = sse_pkg::ST_NEW;
              rsp_d.position = sse_pkg::PosFieldW'(count_q);
            end
          end
          sse_pkg::REQ_ERASE: begin
            if (hit) begin
              dn_re    = 1'b1;
              dn_raddr = PosW'(count_q - CntW'(1));
              done_d   = 1'b0;
              state_d  = S_MOVE;
            end else begin
              rsp_d.status = sse_pkg::ST_ABSENT;
            end
          end
          sse_pkg::REQ_FIND: begin
            if (hit) begin
              rsp_d.status   = sse_pkg::ST_PRESENT;
              rsp_d.position = sse_pkg::PosFieldW'(sp_rdata);
            end else begin
              rsp_d.status = sse_pkg::ST_ABSENT;
            end
          end
          default: begin
            count_d      = '0;
            rsp_d.status = sse_pkg::ST_CLEARED;
          end
        endcase
      end
      S_MOVE: begin
        dn_we          = 1'b1;
        dn_waddr       = sp_rdata;
        dn_wdata       = dn_rdata;
        sp_we          = 1'b1;
        sp_waddr       = dn_rdata;
        sp_wdata       = sp_rdata;
        count_d        = count_q - CntW'(1);
        rsp_d.status   = sse_pkg::ST_ERASED;
        rsp_d.position = '0;
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (done_d) begin
      rsp_d.entry_total = sse_pkg::TotalFieldW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      type_q <= req_i.req_type;
      key_q  <= key_in;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: rtl/core/sse_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module sse_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: tb/sv/sse_checker.sv
// Checker for the sparse set engine: predicts every result and compares it field by field.
`timescale 1ns / 100ps

module sse_checker #(
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned DENSE_DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  sse_pkg::req_t req_i,
  input  logic          done_i,
  input  sse_pkg::rsp_t rsp_i,
  output int            fail_count_o,
  output int            pending_o
);
  import sse_pkg::*;

  localparam int unsigned SparseDepth = 1 << KEY_BITS;

  int unsigned slot_of_key [SparseDepth];
  int unsigned key_at [DENSE_DEPTH];
  int unsigned held;
  rsp_t        outcome_q [$];
  rsp_t        due;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    held         = 0;
  end

  // A slot is trusted only when it lies below the count and the key stored there matches.
  function automatic bit locate(input int unsigned k, output int unsigned pos);
    pos = slot_of_key[k];
    return pos < held && pos < DENSE_DEPTH && key_at[pos] == k;
  endfunction

  function automatic rsp_t set_outcome(input req_t rq);
    rsp_t        r;
    int unsigned k;
    int unsigned hit_pos;
    int unsigned out_pos;
    int unsigned moved;
    k        = 32'(rq.key) & (SparseDepth - 1);
    out_pos  = 0;
    r.status = ST_ABSENT;
    case (rq.req_type)
      REQ_INSERT: begin
        if (locate(k, hit_pos)) begin
          r.status = ST_PRESENT;
          out_pos  = hit_pos;
        end else if (held >= DENSE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key_at[held]   = k;
          slot_of_key[k] = held;
          out_pos        = held;
          held++;
          r.status = ST_NEW;
        end
      end
      REQ_ERASE: begin
        if (locate(k, hit_pos)) begin
          moved              = key_at[held - 1];
          key_at[hit_pos]    = moved;
          slot_of_key[moved] = hit_pos;
          held--;
          r.status = ST_ERASED;
        end
      end
      REQ_FIND: begin
        if (locate(k, hit_pos)) begin
          r.status = ST_PRESENT;
          out_pos  = hit_pos;
        end
      end
      default: begin
        held     = 0;
        r.status = ST_CLEARED;
      end
    endcase
    r.position    = out_pos[PosFieldW-1:0];
    r.entry_total = held[TotalFieldW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      outcome_q.delete();
    end else begin
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          $error("result with no item outstanding: status %0d, position %0d, entry_total %0d",
                 rsp_i.status, rsp_i.position, rsp_i.entry_total);
          fail_count_o++;
        end else begin
          due = outcome_q.pop_front();
          if (rsp_i.status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, rsp_i.status);
            fail_count_o++;
          end
          if (rsp_i.position !== due.position) begin
            $error("position: expected %0d, actual %0d", due.position, rsp_i.position);
            fail_count_o++;
          end
          if (rsp_i.entry_total !== due.entry_total) begin
            $error("entry_total: expected %0d, actual %0d", due.entry_total,
                   rsp_i.entry_total);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        outcome_q.insert(outcome_q.size(), set_outcome(req_i));
      end
    end
    pending_o = outcome_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the sparse set engine: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import sse_pkg::*;

  localparam int unsigned KeyBits     = 16;
  localparam int unsigned DenseDepth  = 1024;
  localparam int unsigned IdleLimit   = 400;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PoolSize    = 48;

  logic        clk;
  logic        rst_n;
  logic        start;
  req_t        req;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  int          fail_count;
  int          pending;
  bit          no_gaps;
  int unsigned idle_cycles;
  logic [15:0] key_pool [PoolSize];

  sparse_set_engine #(
    .KEY_BITS   (KeyBits),
    .DENSE_DEPTH(DenseDepth)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start_i(start),
    .req_i  (req),
    .busy_o (busy),
    .done_o (done),
    .rsp_o  (rsp)
  );

  sse_checker #(
    .KEY_BITS   (KeyBits),
    .DENSE_DEPTH(DenseDepth)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .done_i      (done),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input req_e op, input logic [15:0] key);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= '{req_type: op, key: key};
    do @(posedge clk); while (busy);
  endtask

  // Keys base + i * stride are distinct for any odd stride, so the set fills exactly.
  task automatic fill_to_full();
    int unsigned base;
    int unsigned stride;
    int unsigned pick;
    base   = $urandom;
    stride = $urandom | 1;
    send(REQ_CLEAR, 16'($urandom));
    for (int unsigned i = 0; i < DenseDepth; i++) begin
      send(REQ_INSERT, 16'(base + i * stride));
      if ($urandom_range(0, 15) == 0) send(REQ_FIND, 16'(base + $urandom_range(0, i) * stride));
    end
    for (int unsigned j = 0; j < 40; j++) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: send(REQ_INSERT, 16'(base + (DenseDepth + j) * stride));
        1: send(REQ_INSERT, 16'(base + $urandom_range(0, DenseDepth - 1) * stride));
        2: send(REQ_FIND, 16'($urandom));
        default: send(REQ_FIND, 16'(base + $urandom_range(0, DenseDepth - 1) * stride));
      endcase
    end
    send(REQ_ERASE, 16'(base));
    send(REQ_ERASE, 16'(base + (DenseDepth / 2) * stride));
    send(REQ_ERASE, 16'(base + (DenseDepth - 1) * stride));
    send(REQ_FIND, 16'(base));
    for (int unsigned j = 0; j < 4; j++) begin
      send(REQ_INSERT, 16'(base + (DenseDepth + 100 + j) * stride));
    end
    send(REQ_FIND, 16'(base + (DenseDepth + 102) * stride));
    send(REQ_CLEAR, 16'($urandom));
  endtask

  task automatic churn(input int unsigned count);
    int unsigned pick;
    logic [15:0] key;
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      key  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                          : key_pool[$urandom_range(0, PoolSize - 1)];
      if (pick < 40) send(REQ_INSERT, key);
      else if (pick < 65) send(REQ_ERASE, key);
      else if (pick < 97) send(REQ_FIND, key);
      else send(REQ_CLEAR, key);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    req         = '0;
    no_gaps     = 1'b0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(REQ_FIND, 16'h0000);
    send(REQ_ERASE, 16'h0000);
    send(REQ_INSERT, 16'h0000);
    send(REQ_INSERT, 16'hFFFF);
    send(REQ_INSERT, 16'h5A5A);
    send(REQ_INSERT, 16'hA5A5);
    send(REQ_INSERT, 16'h0000);
    send(REQ_FIND, 16'hFFFF);
    send(REQ_FIND, 16'h1234);
    send(REQ_ERASE, 16'h0000);
    send(REQ_FIND, 16'hA5A5);
    send(REQ_ERASE, 16'hA5A5);
    send(REQ_ERASE, 16'h5A5A);
    send(REQ_FIND, 16'h5A5A);
    send(REQ_ERASE, 16'hFFFF);
    send(REQ_INSERT, 16'h0001);
    send(REQ_INSERT, 16'h0002);
    send(REQ_CLEAR, 16'hFFFF);
    send(REQ_FIND, 16'h0001);
    send(REQ_INSERT, 16'h0002);
    send(REQ_ERASE, 16'h0002);
    send(REQ_CLEAR, 16'h0000);

    fill_to_full();
    repeat (3) churn(240);

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sparse_set_engine.f
rtl/core/sse_pkg.sv
rtl/core/sse_ram.sv
rtl/core/sparse_set_engine.sv
tb/sv/sse_checker.sv
tb/sv/tb_top.sv
